// ----- sv/lifo_stack_with_peek_core_macros.svh -----
// Assertion macros for the LIFO stack core.
`ifndef LIFO_STACK_WITH_PEEK_CORE_MACROS_SVH
`define LIFO_STACK_WITH_PEEK_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on every clock edge out of reset.
`define LSP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lsp: assertion failed");

// Same-cycle implication.
`define LSP_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lsp: implication failed");

// Next-cycle implication.
`define LSP_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lsp: next-cycle implication failed");

`else

`define LSP_ASSERT(label, prop)
`define LSP_ASSERT_IMP(label, pre, post)
`define LSP_ASSERT_NXT(label, pre, post)

`endif

`endif

// ----- sv/lsp_pkg.sv -----
// Package: types, codes and constants of the LIFO stack core.
`default_nettype none

package lsp_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int OP_W      = 2;
    localparam int WORD_W    = 32;
    localparam int POS_W     = 7;
    localparam int STAT_W    = 2;
    localparam int COUNT_W   = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } lsp_op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_BADPOS    = 2'd3
    } lsp_stat_t;

    typedef enum logic [1:0] {
        DSEL_ERR  = 2'd0,
        DSEL_ZERO = 2'd1,
        DSEL_MEM  = 2'd2
    } lsp_dsel_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_LOAD = 2'd2
    } lsp_state_t;

    typedef struct packed {
        logic take;
        logic exec;
        logic load;
    } lsp_cmd_t;

endpackage

`default_nettype wire

// ----- sv/lsp_req_if.sv -----
// Request channel: one stack operation per item.
`default_nettype none

interface lsp_req_if
    import lsp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/lsp_rsp_if.sv -----
// Response channel: one result item per operation.
`default_nettype none

interface lsp_rsp_if
    import lsp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] data;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;

    modport source (output valid, output data, output status, output count,
                    output is_empty, input ready);
    modport sink   (input valid, input data, input status, input count,
                    input is_empty, output ready);
endinterface

`default_nettype wire

// ----- sv/lsp_ctrl.sv -----
// Controller: sequences take, execute and result load for each item.
`default_nettype none
`include "lifo_stack_with_peek_core_macros.svh"

module lsp_ctrl
    import lsp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output lsp_cmd_t      cmd,
    output logic          req_ready,
    output logic          rsp_valid,
    input  wire logic     rsp_ready
);

    lsp_state_t state_reg;
    lsp_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign rsp_valid = out_valid_reg;

    // one phase at a time
    `LSP_ASSERT(a_cmd_onehot, $onehot0({cmd.take, cmd.exec, cmd.load}))
    // a pending result is never overwritten
    `LSP_ASSERT_IMP(a_no_clobber, cmd.load, (!out_valid_reg || rsp_ready))
    // an accepted item always goes from its take to the execute phase
    `LSP_ASSERT_NXT(a_take_exec, cmd.take, cmd.exec)

endmodule

`default_nettype wire

// ----- sv/lsp_dpath.sv -----
// Datapath: stack memory, fill count, operation decode and result register.
`default_nettype none
`include "lifo_stack_with_peek_core_macros.svh"

module lsp_dpath
    import lsp_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire lsp_cmd_t                  cmd,
    input  wire logic [OP_W-1:0]           operation,
    input  wire logic signed [WORD_W-1:0]  value,
    input  wire logic [POS_W-1:0]          position,
    output logic signed [WORD_W-1:0]       data,
    output logic [STAT_W-1:0]              status,
    output logic [COUNT_W-1:0]             count,
    output logic                           is_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [OP_W-1:0]          op_reg;
    logic signed [WORD_W-1:0] value_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic signed [WORD_W-1:0] stack_mem [DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;
    lsp_dsel_t                sel_reg;
    lsp_dsel_t                sel_next;
    lsp_stat_t                status_reg;
    lsp_stat_t                status_next;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;
    logic [PW-1:0]            cnt_ext;
    logic [PW-1:0]            pos_ext;
    logic [PW-1:0]            peek_diff;
    logic [CW-1:0]            count_dec;

    logic signed [WORD_W-1:0] out_data_reg;
    logic [STAT_W-1:0]        out_status_reg;
    logic [COUNT_W-1:0]       out_count_reg;
    logic                     out_empty_reg;

    assign cnt_ext   = PW'(count_reg);
    assign pos_ext   = PW'(pos_reg);
    assign peek_diff = cnt_ext - pos_ext;
    assign count_dec = count_reg - CW'(1);
    assign wr_addr   = count_reg[AW-1:0];

    always_comb
    begin
        status_next = STAT_BADPOS;
        sel_next    = DSEL_ERR;
        count_next  = count_reg;
        wr_en       = 1'b0;
        rd_addr     = count_dec[AW-1:0];
        case (op_reg)
            OP_PUSH:
            begin
                if (count_reg == FULL)
                    status_next = STAT_OVERFLOW;
                else
                begin
                    wr_en       = 1'b1;
                    count_next  = count_reg + CW'(1);
                    sel_next    = DSEL_ZERO;
                    status_next = STAT_OK;
                end
            end
            OP_POP:
            begin
                if (count_reg == '0)
                    status_next = STAT_UNDERFLOW;
                else
                begin
                    count_next  = count_dec;
                    sel_next    = DSEL_MEM;
                    status_next = STAT_OK;
                end
            end
            OP_PEEK:
            begin
                if ((pos_ext != '0) && (pos_ext <= cnt_ext))
                begin
                    rd_addr     = peek_diff[AW-1:0];
                    sel_next    = DSEL_MEM;
                    status_next = STAT_OK;
                end
            end
            default:
            begin
                status_next = STAT_BADPOS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.exec)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg    <= operation;
            value_reg <= value;
            pos_reg   <= position;
        end
        if (cmd.exec)
        begin
            sel_reg    <= sel_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
            stack_mem[wr_addr] <= value_reg;
        if (cmd.exec)
            rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            case (sel_reg)
                DSEL_MEM:  out_data_reg <= rd_data_reg;
                DSEL_ZERO: out_data_reg <= '0;
                default:   out_data_reg <= '1;
            endcase
            out_status_reg <= status_reg;
            out_count_reg  <= cnt_ext[COUNT_W-1:0];
            out_empty_reg  <= (count_reg == '0);
        end
    end

    assign data     = out_data_reg;
    assign status   = out_status_reg;
    assign count    = out_count_reg;
    assign is_empty = out_empty_reg;

    `LSP_ASSERT(a_count_bound, (count_reg <= FULL))
    `LSP_ASSERT_NXT(a_err_keeps_count, (cmd.exec && status_next != STAT_OK), $stable(count_reg))
    `LSP_ASSERT_NXT(a_push_grows, (cmd.exec && wr_en),
                    (count_reg == $past(count_reg) + CW'(1)))

endmodule

`default_nettype wire

// ----- sv/lifo_stack_with_peek_core.sv -----
// Top level of the LIFO stack core with push, pop and peek.
//
//  channel | dir | payload                              | handshake
//  req     | in  | operation, value, position           | valid / ready
//  rsp     | out | data, status, count, is_empty        | valid / ready
//
// Each item passes through take, execute (memory write or registered
// memory read and count update), then load into the result register.
// The registered read of the stack store lies between take and load.
// A result waiting in the output register does not block the next take;
// that item holds in the load phase until the output register frees up.
// rst_n clears the fill count and the control state; memory contents stay.
`default_nettype none

module lifo_stack_with_peek_core
    import lsp_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lsp_req_if.sink    req,
    lsp_rsp_if.source  rsp
);

    lsp_cmd_t cmd;

    lsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .cmd       (cmd),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready)
    );

    lsp_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .operation (req.operation),
        .value     (req.value),
        .position  (req.position),
        .data      (rsp.data),
        .status    (rsp.status),
        .count     (rsp.count),
        .is_empty  (rsp.is_empty)
    );

endmodule

`default_nettype wire
